@@ rtl/pdcp_pkg.sv @@
`default_nettype none

package pdcp_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int MASS_WIDTH  = 32;
    localparam int REST_WIDTH  = 24;
    localparam int STIFF_WIDTH = 17;
    localparam int FRAC_SHIFT  = 30;
    localparam int QUO_WIDTH   = FRAC_SHIFT + 1;
    localparam logic [STIFF_WIDTH-1:0] STIFF_ONE = STIFF_WIDTH'(65536);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] parent_x;
        logic signed [COORD_WIDTH-1:0] parent_y;
        logic signed [COORD_WIDTH-1:0] parent_z;
        logic signed [COORD_WIDTH-1:0] child_x;
        logic signed [COORD_WIDTH-1:0] child_y;
        logic signed [COORD_WIDTH-1:0] child_z;
        logic [MASS_WIDTH-1:0]         parent_inv_mass;
        logic [MASS_WIDTH-1:0]         child_inv_mass;
        logic [REST_WIDTH-1:0]         rest_length;
        logic [STIFF_WIDTH-1:0]        stiffness;
    } pdcp_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] new_parent_x;
        logic signed [COORD_WIDTH-1:0] new_parent_y;
        logic signed [COORD_WIDTH-1:0] new_parent_z;
        logic signed [COORD_WIDTH-1:0] new_child_x;
        logic signed [COORD_WIDTH-1:0] new_child_y;
        logic signed [COORD_WIDTH-1:0] new_child_z;
        logic                          applied;
    } pdcp_out_t;

endpackage

`default_nettype wire

@@ rtl/pdcp_delay.sv @@
`default_nettype none

module pdcp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid_in,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  valid_out,
    output logic [WIDTH-1:0]      data_out
);

    logic [DEPTH-1:0]             valid_reg;
    logic [DEPTH-1:0][WIDTH-1:0]  data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= data_in;
        for (int k = 1; k < DEPTH; k++)
        begin
            data_reg[k] <= data_reg[k-1];
        end
    end

    assign valid_out = valid_reg[DEPTH-1];
    assign data_out  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/pdcp_sqrt.sv @@
`default_nettype none

// Digit-by-digit integer square root, one root bit per register stage.
module pdcp_sqrt #(
    parameter int ROOT_WIDTH = 25
) (
    input  wire logic                      clk,
    input  wire logic [2*ROOT_WIDTH-1:0]   radicand,
    output logic [ROOT_WIDTH-1:0]          root
);

    localparam int RMW = ROOT_WIDTH + 3;
    localparam int SW  = 2 * ROOT_WIDTH;

    logic [ROOT_WIDTH-1:0][RMW-1:0]        rem_cur, rem_next, rem_reg;
    logic [ROOT_WIDTH-1:0][ROOT_WIDTH-1:0] root_cur, root_next, root_reg;
    logic [ROOT_WIDTH-1:0][SW-1:0]         s_cur, s_next, s_reg;

    always_comb
    begin
        logic [RMW-1:0] acc;
        logic [RMW-1:0] trial;
        logic           ge;
        for (int k = 0; k < ROOT_WIDTH; k++)
        begin
            if (k == 0)
            begin
                rem_cur[k]  = '0;
                root_cur[k] = '0;
                s_cur[k]    = radicand;
            end
            else
            begin
                rem_cur[k]  = rem_reg[k-1];
                root_cur[k] = root_reg[k-1];
                s_cur[k]    = s_reg[k-1];
            end
            acc   = {rem_cur[k][ROOT_WIDTH:0], s_cur[k][SW-1 -: 2]};
            trial = {1'b0, root_cur[k], 2'b01};
            ge    = (acc >= trial);
            rem_next[k]  = ge ? (acc - trial) : acc;
            root_next[k] = {root_cur[k][ROOT_WIDTH-2:0], ge};
            s_next[k]    = {s_cur[k][SW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        s_reg    <= s_next;
    end

    assign root = root_reg[ROOT_WIDTH-1];

endmodule

`default_nettype wire

@@ rtl/pdcp_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per register stage.
// Computes floor(num * 2^(QW-1) / den) for num <= den.
module pdcp_div #(
    parameter int NW = 25,
    parameter int DW = 25,
    parameter int QW = 31
) (
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic          clk,
    output logic [QW-1:0]      quo
);

    localparam int RW = DW + 1;

    logic [QW-1:0][RW-1:0] rem_cur, rem_next, rem_reg;
    logic [QW-1:0][DW-1:0] den_cur, den_reg;
    logic [QW-1:0][QW-1:0] q_cur, q_next, q_reg;

    always_comb
    begin
        logic [RW-1:0] rsub;
        logic          ge;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                rem_cur[k] = {{(RW-NW){1'b0}}, num};
                den_cur[k] = den;
                q_cur[k]   = '0;
            end
            else
            begin
                rem_cur[k] = rem_reg[k-1];
                den_cur[k] = den_reg[k-1];
                q_cur[k]   = q_reg[k-1];
            end
            ge   = (rem_cur[k] >= {1'b0, den_cur[k]});
            rsub = ge ? (rem_cur[k] - {1'b0, den_cur[k]}) : rem_cur[k];
            rem_next[k] = {rsub[DW-1:0], 1'b0};
            q_next[k]   = {q_cur[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_cur;
        q_reg   <= q_next;
    end

    assign quo = q_reg[QW-1];

endmodule

`default_nettype wire

@@ rtl/pbd_distance_constraint_projection.sv @@
`default_nettype none

// Distance constraint projection for position-based dynamics.
// Input channel: drive item and raise start for one cycle per item; an item
// is taken at each rising edge with start high and busy low. busy stays low,
// so a new item may be given in every cycle.
// Result channel: done is high for exactly one cycle with the corrected
// endpoints and the applied flag on result. The receiver cannot stall; every
// result must be taken in the cycle it is shown.
// Pipeline: the length square root takes one stage per root bit
// (COORD_WIDTH + 1), the divisions for the unit direction and the mass
// ratios take one stage per quotient bit (31), plus input, square, sum,
// two multiply and one output stage.
// Throughput: one item per cycle.
// Reset: clears all valid bits; items in flight are dropped and no done
// strobe follows until new items are accepted.
module pbd_distance_constraint_projection (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pdcp_pkg::pdcp_in_t item,
    output logic                    done,
    output pdcp_pkg::pdcp_out_t     result
);

    import pdcp_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int RB  = CW + 1;
    localparam int SQW = 2 * RB;
    localparam int EW  = (RB > REST_WIDTH) ? RB : REST_WIDTH;
    localparam int QW  = QUO_WIDTH;
    localparam int AW  = ((CW > EW) ? CW : EW) + 2;
    localparam int LAT = RB + QW + 6;
    localparam logic signed [AW-1:0] CMAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] CMIN = ~CMAX;
    localparam logic [QW:0] ONE_Q = {2'b01, {(QW-1){1'b0}}};

    typedef struct packed {
        logic [2:0][CW-1:0]     p;
        logic [2:0][CW-1:0]     c;
        logic [2:0][CW:0]       dmag;
        logic [2:0]             dneg;
        logic [MASS_WIDTH-1:0]  mp;
        logic [MASS_WIDTH-1:0]  mc;
        logic [MASS_WIDTH:0]    w;
        logic [REST_WIDTH-1:0]  rest;
        logic [STIFF_WIDTH-1:0] stiff;
    } side1_t;

    typedef struct packed {
        logic [2:0][CW-1:0] p;
        logic [2:0][CW-1:0] c;
        logic [2:0]         dneg;
        logic               eneg;
        logic [EW-1:0]      g;
        logic               skip;
    } side2_t;

    function automatic logic [CW-1:0] sat_coord(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v;
        if (v > CMAX)
        begin
            t = CMAX;
        end
        else if (v < CMIN)
        begin
            t = CMIN;
        end
        return t[CW-1:0];
    endfunction

    assign busy = 1'b0;

    // Stage 1: differences, inverse-mass sum, stiffness clamp
    side1_t s1_next, s1_reg;
    logic   v1_reg;

    always_comb
    begin
        logic signed [CW:0] d;
        s1_next.p[0]  = item.parent_x;
        s1_next.p[1]  = item.parent_y;
        s1_next.p[2]  = item.parent_z;
        s1_next.c[0]  = item.child_x;
        s1_next.c[1]  = item.child_y;
        s1_next.c[2]  = item.child_z;
        for (int i = 0; i < 3; i++)
        begin
            d = $signed({s1_next.c[i][CW-1], s1_next.c[i]})
              - $signed({s1_next.p[i][CW-1], s1_next.p[i]});
            s1_next.dneg[i] = d[CW];
            s1_next.dmag[i] = d[CW] ? (~d + 1'b1) : d;
        end
        s1_next.mp    = item.parent_inv_mass;
        s1_next.mc    = item.child_inv_mass;
        s1_next.w     = {1'b0, item.parent_inv_mass} + {1'b0, item.child_inv_mass};
        s1_next.rest  = item.rest_length;
        s1_next.stiff = (item.stiffness > STIFF_ONE) ? STIFF_ONE : item.stiffness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Stages 2 and 3: squares, then their sum
    logic [2:0][SQW-1:0] sq_reg;
    logic [SQW-1:0]      ssum_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= {{(SQW-RB){1'b0}}, s1_reg.dmag[i]}
                       * {{(SQW-RB){1'b0}}, s1_reg.dmag[i]};
        end
        ssum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    logic [RB-1:0] len;

    pdcp_sqrt #(
        .ROOT_WIDTH(RB)
    ) u_sqrt (
        .clk      (clk),
        .radicand (ssum_reg),
        .root     (len)
    );

    side1_t sd1;
    logic   vd1;

    pdcp_delay #(
        .WIDTH($bits(side1_t)),
        .DEPTH(2 + RB)
    ) u_dly1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1_reg),
        .data_in   (s1_reg),
        .valid_out (vd1),
        .data_out  (sd1)
    );

    // Length error and scaled correction magnitude, aligned with len
    side2_t s2_next, sd2;
    logic   vd2;

    always_comb
    begin
        logic [EW-1:0]             len_e;
        logic [EW-1:0]             rest_e;
        logic [EW-1:0]             emag;
        logic [EW+STIFF_WIDTH-1:0] prod;
        len_e  = {{(EW-RB){1'b0}}, len};
        rest_e = {{(EW-REST_WIDTH){1'b0}}, sd1.rest};
        s2_next.p    = sd1.p;
        s2_next.c    = sd1.c;
        s2_next.dneg = sd1.dneg;
        s2_next.eneg = (len_e < rest_e);
        emag = s2_next.eneg ? (rest_e - len_e) : (len_e - rest_e);
        prod = {{(EW){1'b0}}, sd1.stiff} * {{(STIFF_WIDTH){1'b0}}, emag};
        s2_next.g    = prod[EW+15:16];
        s2_next.skip = (len == '0) || (sd1.w == '0);
    end

    pdcp_delay #(
        .WIDTH($bits(side2_t)),
        .DEPTH(QW)
    ) u_dly2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vd1),
        .data_in   (s2_next),
        .valid_out (vd2),
        .data_out  (sd2)
    );

    logic [2:0][QW-1:0] u_dir;
    logic [QW-1:0]      rp, rc;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis_div
        pdcp_div #(
            .NW(CW + 1),
            .DW(RB),
            .QW(QW)
        ) u_div_dir (
            .num (sd1.dmag[i]),
            .den (len),
            .clk (clk),
            .quo (u_dir[i])
        );
    end

    pdcp_div #(
        .NW(MASS_WIDTH),
        .DW(MASS_WIDTH + 1),
        .QW(QW)
    ) u_div_mp (
        .num (sd1.mp),
        .den (sd1.w),
        .clk (clk),
        .quo (rp)
    );

    pdcp_div #(
        .NW(MASS_WIDTH),
        .DW(MASS_WIDTH + 1),
        .QW(QW)
    ) u_div_mc (
        .num (sd1.mc),
        .den (sd1.w),
        .clk (clk),
        .quo (rc)
    );

    // Stage q: per-axis correction, stage m: split by mass ratio
    side2_t             sq_side_reg, sm_side_reg;
    logic               vq_reg, vm_reg;
    logic [2:0][EW-1:0] q_reg;
    logic [QW-1:0]      rp_reg, rc_reg;
    logic [2:0][EW-1:0] movp_reg, movc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vm_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            vq_reg <= vd2;
            vm_reg <= vq_reg;
            done   <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [EW+QW-1:0] pq;
        logic [EW+QW-1:0] pp;
        logic [EW+QW-1:0] pc;
        for (int i = 0; i < 3; i++)
        begin
            pq = {{(EW){1'b0}}, u_dir[i]} * {{(QW){1'b0}}, sd2.g};
            q_reg[i] <= pq[EW+FRAC_SHIFT-1:FRAC_SHIFT];
            pp = {{(QW){1'b0}}, q_reg[i]} * {{(EW){1'b0}}, rp_reg};
            pc = {{(QW){1'b0}}, q_reg[i]} * {{(EW){1'b0}}, rc_reg};
            movp_reg[i] <= pp[EW+FRAC_SHIFT-1:FRAC_SHIFT];
            movc_reg[i] <= pc[EW+FRAC_SHIFT-1:FRAC_SHIFT];
        end
        rp_reg      <= rp;
        rc_reg      <= rc;
        sq_side_reg <= sd2;
        sm_side_reg <= sq_side_reg;
    end

    // Output stage: apply signed moves and saturate, or pass through on skip
    always_ff @(posedge clk)
    begin
        logic signed [AW-1:0] pe, ce, mvp, mvc, np, nc;
        logic [2:0][CW-1:0]   po, co;
        logic                 neg;
        for (int i = 0; i < 3; i++)
        begin
            pe  = {{(AW-CW){sm_side_reg.p[i][CW-1]}}, sm_side_reg.p[i]};
            ce  = {{(AW-CW){sm_side_reg.c[i][CW-1]}}, sm_side_reg.c[i]};
            mvp = {{(AW-EW){1'b0}}, movp_reg[i]};
            mvc = {{(AW-EW){1'b0}}, movc_reg[i]};
            neg = sm_side_reg.dneg[i] ^ sm_side_reg.eneg;
            np  = neg ? (pe - mvp) : (pe + mvp);
            nc  = neg ? (ce + mvc) : (ce - mvc);
            po[i] = sm_side_reg.skip ? sm_side_reg.p[i] : sat_coord(np);
            co[i] = sm_side_reg.skip ? sm_side_reg.c[i] : sat_coord(nc);
        end
        result.new_parent_x <= po[0];
        result.new_parent_y <= po[1];
        result.new_parent_z <= po[2];
        result.new_child_x  <= co[0];
        result.new_child_y  <= co[1];
        result.new_child_z  <= co[2];
        result.applied      <= !sm_side_reg.skip;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("accepted item gave no result at the expected cycle");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted item");

    a_mass_split: assert property (@(posedge clk) disable iff (!rst_n)
        vd2 && !sd2.skip |-> (({1'b0, rp} + {1'b0, rc}) <= ONE_Q)
                          && (({1'b0, rp} + {1'b0, rc}) >= (ONE_Q - 1'b1)))
        else $error("inverse-mass ratios do not sum to one");

    a_unit_dir: assert property (@(posedge clk) disable iff (!rst_n)
        vd2 && !sd2.skip |-> ({1'b0, u_dir[0]} <= ONE_Q) && ({1'b0, u_dir[1]} <= ONE_Q)
                          && ({1'b0, u_dir[2]} <= ONE_Q))
        else $error("direction component above one");

endmodule

`default_nettype wire

@@ tb/sv/pdcp_checker.sv @@
`timescale 1ns / 100ps

module pdcp_checker
    import pdcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      busy,
    input  wire pdcp_in_t  item,
    input  wire logic      done,
    input  wire pdcp_out_t result,
    output int             fail_count,
    output int             pending,
    output int             checked,
    output int             skipped
);

    pdcp_out_t projected_q[$];

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [33:0] wide_sqrt(logic [67:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    function automatic pdcp_out_t project(pdcp_in_t it);
        pdcp_out_t o;
        longint pos_p[3];
        longint pos_c[3];
        longint dlt[3];
        logic [67:0] sq;
        logic [63:0] len;
        logic [63:0] w;
        logic [63:0] st;
        logic [63:0] emag;
        logic [63:0] g;
        logic [63:0] rp;
        logic [63:0] rc;
        logic [63:0] dmag;
        logic [63:0] u;
        logic [127:0] q;
        logic [127:0] mp;
        logic [127:0] mc;
        longint movp;
        longint movc;
        logic eneg;
        logic dneg;
        longint np[3];
        longint nc[3];
        pos_p[0] = it.parent_x; pos_p[1] = it.parent_y; pos_p[2] = it.parent_z;
        pos_c[0] = it.child_x;  pos_c[1] = it.child_y;  pos_c[2] = it.child_z;
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            dlt[i] = pos_c[i] - pos_p[i];
            dmag = dlt[i] < 0 ? -dlt[i] : dlt[i];
            sq += {4'd0, dmag} * {4'd0, dmag};
        end
        len = wide_sqrt(sq);
        w = {32'd0, it.parent_inv_mass} + {32'd0, it.child_inv_mass};
        if (len == 0 || w == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                np[i] = pos_p[i];
                nc[i] = pos_c[i];
            end
            o.applied = 1'b0;
        end
        else
        begin
            st = it.stiffness > STIFF_ONE ? STIFF_ONE : it.stiffness;
            eneg = len < it.rest_length;
            emag = eneg ? it.rest_length - len : len - it.rest_length;
            g = (st * emag) >> 16;
            rp = ({32'd0, it.parent_inv_mass} << FRAC_SHIFT) / w;
            rc = ({32'd0, it.child_inv_mass} << FRAC_SHIFT) / w;
            for (int i = 0; i < 3; i++)
            begin
                dneg = dlt[i] < 0;
                dmag = dneg ? -dlt[i] : dlt[i];
                u = (dmag << FRAC_SHIFT) / len;
                q = ({64'd0, u} * {64'd0, g}) >> FRAC_SHIFT;
                mp = (q * rp) >> FRAC_SHIFT;
                mc = (q * rc) >> FRAC_SHIFT;
                movp = mp[63:0];
                movc = mc[63:0];
                if (dneg != eneg)
                begin
                    movp = -movp;
                    movc = -movc;
                end
                np[i] = pos_p[i] + movp;
                nc[i] = pos_c[i] - movc;
            end
            o.applied = 1'b1;
        end
        o.new_parent_x = clamp_coord(np[0]);
        o.new_parent_y = clamp_coord(np[1]);
        o.new_parent_z = clamp_coord(np[2]);
        o.new_child_x  = clamp_coord(nc[0]);
        o.new_child_y  = clamp_coord(nc[1]);
        o.new_child_z  = clamp_coord(nc[2]);
        return o;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        checked = 0;
        skipped = 0;
    end

    always @(posedge clk)
    begin
        pdcp_out_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (projected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result %h", result);
                end
                else
                begin
                    exp_r = projected_q.pop_front();
                    checked++;
                    if (!exp_r.applied) skipped++;
                    if (result !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: result mismatch exp %h got %h", exp_r, result);
                    end
                end
            end
            if (start && !busy)
                projected_q = {projected_q, project(item)};
            pending = projected_q.size();
        end
    end

endmodule

@@ tb/sv/tb_pbd_distance_constraint_projection.sv @@
`timescale 1ns / 100ps

module tb_pbd_distance_constraint_projection;
    import pdcp_pkg::*;

    localparam int LATENCY = COORD_WIDTH + 37;
    localparam int LIMIT   = 400000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    pdcp_in_t  item;
    logic      done;
    pdcp_out_t result;
    int        fail_count;
    int        pending;
    int        checked;
    int        skipped;
    int        cycle_count;
    int        sent;

    pbd_distance_constraint_projection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .done(done), .result(result)
    );

    pdcp_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .fail_count(fail_count),
        .pending(pending), .checked(checked), .skipped(skipped)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int mode);
        case (mode)
            0: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            1: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            2: return COORD_WIDTH'($urandom_range(0, 1 << 18) - (1 << 17));
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [MASS_WIDTH-1:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1 << 17);
            default: return $urandom;
        endcase
    endfunction

    // Hold an item until it is accepted; the next item replaces it or the caller drops start.
    task automatic send(pdcp_in_t it);
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_gapped(pdcp_in_t it);
        int gap;
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sent++;
        @(negedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80)
                                          : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic pdcp_in_t rand_item();
        pdcp_in_t it;
        int mode;
        mode = $urandom_range(0, 9);
        it.parent_x = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        it.parent_y = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        it.parent_z = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        it.child_x  = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        it.child_y  = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        it.child_z  = rand_coord(mode < 7 ? 2 : $urandom_range(0, 3));
        if (mode == 9)
        begin
            it.child_x = it.parent_x;
            it.child_y = it.parent_y;
            it.child_z = it.parent_z;
        end
        it.parent_inv_mass = rand_mass();
        it.child_inv_mass  = rand_mass();
        it.rest_length = ($urandom_range(0, 1)) ? REST_WIDTH'($urandom_range(0, 1 << 18))
                                                : REST_WIDTH'($urandom);
        case ($urandom_range(0, 4))
            0: it.stiffness = STIFF_ONE;
            1: it.stiffness = '1;
            default: it.stiffness = STIFF_WIDTH'($urandom_range(0, 65536));
        endcase
        if ($urandom_range(0, 7) == 0) it.stiffness = STIFF_WIDTH'($urandom);
        return it;
    endfunction

    initial
    begin
        pdcp_in_t it;
        int wait_cycles;
        cycle_count = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero length, fixed masses, clamp, saturation, zero move.
        it = '0;
        it.parent_inv_mass = 32'h10000;
        it.child_inv_mass = 32'h10000;
        it.stiffness = STIFF_ONE;
        send(it);
        it.child_x = 24'sd65536;
        it.parent_inv_mass = '0;
        it.child_inv_mass = '0;
        send(it);
        it.parent_inv_mass = 32'h10000;
        it.child_inv_mass = '0;
        it.rest_length = 24'd65536;
        send(it);
        it.stiffness = '1;
        it.rest_length = 24'd131072;
        send(it);
        it.stiffness = '0;
        send(it);
        it.stiffness = STIFF_ONE;
        it.parent_x = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        it.child_x  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        it.parent_y = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        it.child_y  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        it.parent_z = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        it.child_z  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        it.parent_inv_mass = '1;
        it.child_inv_mass = '1;
        it.rest_length = '0;
        send(it);
        it.rest_length = '1;
        send(it);
        it.parent_x = 24'sd0; it.parent_y = 24'sd0; it.parent_z = 24'sd0;
        it.child_x = 24'sd1; it.child_y = 24'sd0; it.child_z = 24'sd0;
        it.rest_length = 24'd1;
        send(it);
        it.rest_length = 24'd3;
        it.child_inv_mass = '0;
        send(it);
        for (int i = 0; i < 12; i++)
            send(rand_item());

        for (int i = 0; i < 950; i++)
            send_gapped(rand_item());
        start <= 1'b0;

        while (pending > 0) @(negedge clk);
        wait_cycles = 0;
        while (wait_cycles < LATENCY + 10)
        begin
            @(negedge clk);
            wait_cycles++;
        end

        $display("Sent %0d items, checked %0d results (%0d skipped as degenerate).",
                 sent, checked, skipped);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
